// ===== hdl/fbrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared types and constants of the framebuffer span and rectangle fill engine.
// ----------------------------------------------------------------------------
package fbrf_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int SPAN_W      = DIM_W + 1;
    localparam int COLOR_W     = 32;
    localparam int REQ_W       = 3;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

    typedef enum logic [REQ_W-1:0] {
        REQ_SET_PIXEL  = 3'd0,
        REQ_HSPAN      = 3'd1,
        REQ_VSPAN      = 3'd2,
        REQ_RECT_FILL  = 3'd3,
        REQ_READ_PIXEL = 3'd4,
        REQ_FILL_FRAME = 3'd5
    } req_code_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic               load;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] col_last;
        logic [COORD_W-1:0] row_first;
        logic [COORD_W-1:0] row_last;
        logic [ADDR_W-1:0]  base;
    } walk_cmd_t;

    typedef struct packed {
        logic busy;
    } walk_stat_t;

endpackage

// ===== hdl/fbrf_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_req_if
// Request channel: valid, ready and the fields of one drawing request.
// ----------------------------------------------------------------------------
interface fbrf_req_if;
    import fbrf_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col_end;
    logic [COORD_W-1:0] row_end;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
    logic [COLOR_W-1:0] color;

    modport source (
        output valid, req_type, col, row, col_end, row_end, rect_width, rect_height, color,
        input  ready
    );

    modport sink (
        input  valid, req_type, col, row, col_end, row_end, rect_width, rect_height, color,
        output ready
    );
endinterface

// ===== hdl/fbrf_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_rsp_if
// Result channel: valid, ready, the read-back color and the clip flag.
// ----------------------------------------------------------------------------
interface fbrf_rsp_if;
    import fbrf_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_color;
    logic               clipped;

    modport source (
        output valid, read_color, clipped,
        input  ready
    );

    modport sink (
        input  valid, read_color, clipped,
        output ready
    );
endinterface

// ===== hdl/fbrf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fbrf_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_walk
// Pixel walker: steps column and row counters over a clipped block and
// issues one store write per cycle, advancing the address by one per pixel
// and by the row stride per row.
// ----------------------------------------------------------------------------
module fbrf_walk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbrf_pkg::walk_cmd_t             cmd,
    input  logic [fbrf_pkg::DIM_W-1:0]      stride,
    output fbrf_pkg::walk_stat_t            stat,
    output logic                            we,
    output logic [fbrf_pkg::ADDR_W-1:0]     waddr
);
    import fbrf_pkg::*;

    logic               active_reg, active_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_first_reg, col_first_next;
    logic [COORD_W-1:0] col_last_reg, col_last_next;
    logic [COORD_W-1:0] row_last_reg, row_last_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  line_reg, line_next;
    logic [ADDR_W-1:0]  line_step;

    assign line_step = line_reg + ADDR_W'(stride);

    always_comb
    begin
        active_next    = active_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        row_last_next  = row_last_reg;
        addr_next      = addr_reg;
        line_next      = line_reg;
        if (cmd.load)
        begin
            active_next    = 1'b1;
            col_next       = cmd.col_first;
            row_next       = cmd.row_first;
            col_first_next = cmd.col_first;
            col_last_next  = cmd.col_last;
            row_last_next  = cmd.row_last;
            addr_next      = cmd.base;
            line_next      = cmd.base;
        end
        else if (active_reg)
        begin
            if (col_reg != col_last_reg)
            begin
                col_next  = col_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            else if (row_reg != row_last_reg)
            begin
                row_next  = row_reg + 1'b1;
                col_next  = col_first_reg;
                line_next = line_step;
                addr_next = line_step;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        col_first_reg <= col_first_next;
        col_last_reg  <= col_last_next;
        row_last_reg  <= row_last_next;
        addr_reg      <= addr_next;
        line_reg      <= line_next;
    end

    assign stat.busy = active_reg;
    assign we        = active_reg;
    assign waddr     = addr_reg;

endmodule

// ===== hdl/fbrf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_seq
// Request sequencer: decodes a request into a clipped pixel block, computes
// the start address, starts the walker or the read, and holds the result.
// ----------------------------------------------------------------------------
module fbrf_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    fbrf_req_if.sink                      req,
    fbrf_rsp_if.source                    rsp,
    input  logic [fbrf_pkg::DIM_W-1:0]    eff_width,
    input  logic [fbrf_pkg::DIM_W-1:0]    eff_height,
    output fbrf_pkg::walk_cmd_t           walk_cmd,
    input  fbrf_pkg::walk_stat_t          walk_stat,
    output logic                          rd_en,
    output logic [fbrf_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [fbrf_pkg::COLOR_W-1:0]  rd_data,
    output logic [fbrf_pkg::COLOR_W-1:0]  wr_color
);
    import fbrf_pkg::*;

    seq_state_t         state_reg, state_next;
    logic               is_read_reg, is_read_next;
    logic               draw_reg, draw_next;
    logic               clip_reg, clip_next;
    logic [COORD_W-1:0] c0_reg, c0_next;
    logic [COORD_W-1:0] r0_reg, r0_next;
    logic [COORD_W-1:0] cl_reg, cl_next;
    logic [COORD_W-1:0] rl_reg, rl_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               res_valid_reg, res_valid_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    logic               res_clip_reg, res_clip_next;

    logic [COORD_W-1:0] c0_dec, r0_dec;
    logic [SPAN_W-1:0]  c1_dec, r1_dec;
    logic               ok_dec;
    logic               col_out, row_out;
    logic [DIM_W-1:0]   w_last, h_last;
    logic [DIM_W+COORD_W-1:0] row_base;
    logic [ADDR_W-1:0]  start_addr;

    assign w_last = eff_width - 1'b1;
    assign h_last = eff_height - 1'b1;

    always_comb
    begin
        c0_dec = req.col;
        r0_dec = req.row;
        c1_dec = SPAN_W'(req.col);
        r1_dec = SPAN_W'(req.row);
        ok_dec = 1'b0;
        case (req.req_type)
            REQ_SET_PIXEL,
            REQ_READ_PIXEL:
            begin
                ok_dec = 1'b1;
            end
            REQ_HSPAN:
            begin
                c1_dec = SPAN_W'(req.col_end);
                ok_dec = (req.col_end >= req.col);
            end
            REQ_VSPAN:
            begin
                r1_dec = SPAN_W'(req.row_end);
                ok_dec = (req.row_end >= req.row);
            end
            REQ_RECT_FILL:
            begin
                c1_dec = SPAN_W'(req.col) + SPAN_W'(req.rect_width) - 1'b1;
                r1_dec = SPAN_W'(req.row) + SPAN_W'(req.rect_height) - 1'b1;
                ok_dec = (req.rect_width != '0) && (req.rect_height != '0);
            end
            REQ_FILL_FRAME:
            begin
                c0_dec = '0;
                r0_dec = '0;
                c1_dec = SPAN_W'(w_last);
                r1_dec = SPAN_W'(h_last);
                ok_dec = (eff_width != '0) && (eff_height != '0);
            end
            default:
            begin
                ok_dec = 1'b0;
            end
        endcase
        col_out = (c1_dec >= SPAN_W'(eff_width));
        row_out = (r1_dec >= SPAN_W'(eff_height));
    end

    assign row_base   = r0_reg * eff_width;
    assign start_addr = row_base[ADDR_W-1:0] + ADDR_W'(c0_reg);

    always_comb
    begin
        state_next     = state_reg;
        is_read_next   = is_read_reg;
        draw_next      = draw_reg;
        clip_next      = clip_reg;
        c0_next        = c0_reg;
        r0_next        = r0_reg;
        cl_next        = cl_reg;
        rl_next        = rl_reg;
        color_next     = color_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_color_next = res_color_reg;
        res_clip_next  = res_clip_reg;
        walk_cmd       = '0;
        rd_en          = 1'b0;
        rd_addr        = start_addr;
        req.ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    is_read_next = (req.req_type == REQ_READ_PIXEL);
                    clip_next    = ok_dec && (col_out || row_out);
                    draw_next    = ok_dec && (SPAN_W'(c0_dec) < SPAN_W'(eff_width))
                                   && (SPAN_W'(r0_dec) < SPAN_W'(eff_height));
                    c0_next      = c0_dec;
                    r0_next      = r0_dec;
                    cl_next      = col_out ? w_last[COORD_W-1:0] : c1_dec[COORD_W-1:0];
                    rl_next      = row_out ? h_last[COORD_W-1:0] : r1_dec[COORD_W-1:0];
                    color_next   = req.color;
                    state_next   = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (is_read_reg)
                begin
                    rd_en      = draw_reg;
                    state_next = ST_DONE;
                end
                else if (draw_reg)
                begin
                    walk_cmd.load      = 1'b1;
                    walk_cmd.col_first = c0_reg;
                    walk_cmd.col_last  = cl_reg;
                    walk_cmd.row_first = r0_reg;
                    walk_cmd.row_last  = rl_reg;
                    walk_cmd.base      = start_addr;
                    state_next         = ST_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (!walk_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || rsp.ready)
                begin
                    res_valid_next = 1'b1;
                    res_color_next = (is_read_reg && draw_reg) ? rd_data : '0;
                    res_clip_next  = clip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_read_reg   <= is_read_next;
        draw_reg      <= draw_next;
        clip_reg      <= clip_next;
        c0_reg        <= c0_next;
        r0_reg        <= r0_next;
        cl_reg        <= cl_next;
        rl_reg        <= rl_next;
        color_reg     <= color_next;
        res_color_reg <= res_color_next;
        res_clip_reg  <= res_clip_next;
    end

    assign rsp.valid      = res_valid_reg;
    assign rsp.read_color = res_color_reg;
    assign rsp.clipped    = res_clip_reg;
    assign wr_color       = color_reg;

endmodule

// ===== hdl/framebuffer_span_rect_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_span_rect_fill
// Framebuffer engine that sets pixels, draws spans, fills rectangles or the
// whole frame and reads pixels back, with frame size registers on APB.
// ----------------------------------------------------------------------------
// A request is taken in idle and set up, then its in-frame pixels are walked with
// one store write per cycle; requests that write nothing go from setup to done.
// The result is registered in the done state before a new request is taken;
// while a result waits, the next one is held back.
// Reset sets a 1 by 1 frame and clears all control state; the pixel store is
// not cleared and holds undefined data until written.
module framebuffer_span_rect_fill (
    input  logic                           clk,
    input  logic                           rst_n,
    fbrf_req_if.sink                       req,
    fbrf_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbrf_pkg::PADDR_W-1:0]   paddr,
    input  logic [fbrf_pkg::PDATA_W-1:0]   pwdata,
    output logic [fbrf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import fbrf_pkg::*;

    logic [DIM_W-1:0]   frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]   frame_height_reg, frame_height_next;
    logic [DIM_W-1:0]   eff_width, eff_height;
    logic               reg_write;
    reg_index_t         reg_sel;

    walk_cmd_t          walk_cmd;
    walk_stat_t         walk_stat;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COLOR_W-1:0] rd_data;
    logic [COLOR_W-1:0] wr_color;
    logic [ADDR_W-1:0]  ram_addr;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (reg_write)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[DIM_W-1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(1);
            frame_height_reg <= DIM_W'(1);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign eff_width  = (frame_width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : frame_width_reg;
    assign eff_height = (frame_height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frame_height_reg;

    fbrf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .walk_cmd   (walk_cmd),
        .walk_stat  (walk_stat),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_color   (wr_color)
    );

    fbrf_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (walk_cmd),
        .stride (eff_width),
        .stat   (walk_stat),
        .we     (wr_en),
        .waddr  (wr_addr)
    );

    assign ram_addr = wr_en ? wr_addr : rd_addr;

    fbrf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .re    (rd_en),
        .addr  (ram_addr),
        .wdata (wr_color),
        .rdata (rd_data)
    );

endmodule

// ===== hdl/fbrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_checker
// Port-level assertions for the framebuffer fill engine, bound to the top.
// ----------------------------------------------------------------------------
module fbrf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [fbrf_pkg::COLOR_W-1:0]   rsp_read_color,
    input logic                           rsp_clipped
);
    import fbrf_pkg::*;

    // The engine works on one request at a time.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a request is in progress");

    // A clipped result never carries pixel data.
    a_clip_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_clipped |-> rsp_read_color == '0)
        else $error("clipped result with nonzero color");

    // A new result only appears while the request side is held off.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a request in progress");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_color)
            && $stable(rsp_clipped))
        else $error("stalled result changed");

endmodule

bind framebuffer_span_rect_fill fbrf_checker u_fbrf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_color (rsp.read_color),
    .rsp_clipped    (rsp.clipped)
);

// ===== tb/fbrf_draw_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_draw_monitor
// Watches the request, result and register ports of the framebuffer engine.
// It keeps its own pixel store and frame size, works out the result of each
// request transfer, and compares every result transfer field by field against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fbrf_draw_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    fbrf_req_if                          req,
    fbrf_rsp_if                          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [fbrf_pkg::PADDR_W-1:0] paddr,
    input  logic [fbrf_pkg::PDATA_W-1:0] pwdata,
    output int                           pending,
    output int                           fail_count
);
    import fbrf_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               clipped;
    } draw_result_t;

    logic [COLOR_W-1:0] pixel_mem [STORE_DEPTH];
    logic [DIM_W-1:0]   frame_w;
    logic [DIM_W-1:0]   frame_h;
    draw_result_t       owed_results [$];
    int                 errors = 0;

    assign fail_count = errors;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned limit);
        int unsigned val;
        val = 32'(v);
        return (val > limit) ? limit : val;
    endfunction

    // Inclusive block; any pixel outside the frame exists exactly when the
    // far corner lies outside it, so only the in-frame part is walked.
    function automatic logic paint_block(input int unsigned c0, c1, r0, r1,
                                         input logic [COLOR_W-1:0] color);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        w = clamp_dim(frame_w, MAX_WIDTH);
        h = clamp_dim(frame_h, MAX_HEIGHT);
        for (r = r0; r <= r1 && r < h; r++)
            for (c = c0; c <= c1 && c < w; c++)
                pixel_mem[r * w + c] = color;
        return (c1 >= w) || (r1 >= h);
    endfunction

    function automatic draw_result_t draw_outcome(
        input logic [REQ_W-1:0]   kind,
        input logic [COORD_W-1:0] col,
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col_end,
        input logic [COORD_W-1:0] row_end,
        input logic [DIM_W-1:0]   rect_width,
        input logic [DIM_W-1:0]   rect_height,
        input logic [COLOR_W-1:0] color
    );
        draw_result_t res;
        int unsigned  w;
        int unsigned  h;
        res = '0;
        w = clamp_dim(frame_w, MAX_WIDTH);
        h = clamp_dim(frame_h, MAX_HEIGHT);
        case (kind)
            REQ_SET_PIXEL:
                res.clipped = paint_block(32'(col), 32'(col), 32'(row), 32'(row), color);
            REQ_HSPAN:
                if (col_end >= col)
                    res.clipped = paint_block(32'(col), 32'(col_end), 32'(row), 32'(row),
                                              color);
            REQ_VSPAN:
                if (row_end >= row)
                    res.clipped = paint_block(32'(col), 32'(col), 32'(row), 32'(row_end),
                                              color);
            REQ_RECT_FILL:
                if (rect_width != 0 && rect_height != 0)
                    res.clipped = paint_block(32'(col), 32'(col) + 32'(rect_width) - 32'd1,
                                              32'(row), 32'(row) + 32'(rect_height) - 32'd1,
                                              color);
            REQ_READ_PIXEL:
                if (32'(col) < w && 32'(row) < h)
                    res.read_color = pixel_mem[32'(row) * w + 32'(col)];
                else
                    res.clipped = 1'b1;
            REQ_FILL_FRAME:
                if (w != 0 && h != 0)
                    void'(paint_block(0, w - 1, 0, h - 1, color));
            default: ;
        endcase
        return res;
    endfunction

    task automatic log_failure(input string what);
        errors++;
        $display("%0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t seen;
        draw_result_t want;
        if (!rst_n)
        begin
            frame_w = DIM_W'(1);
            frame_h = DIM_W'(1);
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                seen.read_color = rsp.read_color;
                seen.clipped    = rsp.clipped;
                if (owed_results.size() == 0)
                begin
                    log_failure($sformatf("result: expected none, actual %08h clip %0b",
                                          seen.read_color, seen.clipped));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (seen.read_color !== want.read_color)
                        log_failure($sformatf("read_color: expected %08h, actual %08h",
                                              want.read_color, seen.read_color));
                    if (seen.clipped !== want.clipped)
                        log_failure($sformatf("clipped: expected %0b, actual %0b",
                                              want.clipped, seen.clipped));
                end
            end
            if (req.valid && req.ready)
                owed_results.push_back(draw_outcome(req.req_type, req.col, req.row,
                                                    req.col_end, req.row_end,
                                                    req.rect_width, req.rect_height,
                                                    req.color));
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[PADDR_W-1:2]))
                    REG_FRAME_WIDTH:  frame_w = pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT: frame_h = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            pending <= owed_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives drawing requests and frame size writes into the framebuffer engine,
// with random gaps on the request side and random stalls on the result side.
// A directed pass covers the corner cases, then random phases each set a new
// frame size and send mostly well-formed requests; the monitor checks results.
// ----------------------------------------------------------------------------
module tb_top;
    import fbrf_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int ITEM_TARGET = 1000;
    localparam int FAST_AREA   = 4096;

    localparam logic [REQ_W-1:0] REQ_RESERVED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RESERVED_B = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [COORD_W-1:0] col, row, col_end, row_end;
        logic [DIM_W-1:0]   rect_width, rect_height;
        logic [COLOR_W-1:0] color;
    } draw_item_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending;
    int                 fail_count;

    int unsigned eff_w = 1;
    int unsigned eff_h = 1;
    int unsigned useful_count = 0;
    int unsigned read_count = 0;
    int unsigned span_count = 0;
    int unsigned fill_count = 0;
    int unsigned frame_count = 0;
    int unsigned stall_cycles = 0;
    bit          send_quiet = 1'b0;
    bit          rsp_quiet = 1'b0;

    fbrf_req_if req_ch ();
    fbrf_rsp_if rsp_ch ();

    framebuffer_span_rect_fill DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fbrf_draw_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    function automatic draw_item_t make_item(input logic [REQ_W-1:0] kind,
                                             input int unsigned col, row, col_end, row_end,
                                             input int unsigned rect_width, rect_height,
                                             input logic [COLOR_W-1:0] color);
        draw_item_t it;
        it.kind        = kind;
        it.col         = COORD_W'(col);
        it.row         = COORD_W'(row);
        it.col_end     = COORD_W'(col_end);
        it.row_end     = COORD_W'(row_end);
        it.rect_width  = DIM_W'(rect_width);
        it.rect_height = DIM_W'(rect_height);
        it.color       = color;
        return it;
    endfunction

    function automatic int unsigned pick_pos(input int unsigned dim);
        if (dim == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, dim - 1);
    endfunction

    function automatic int unsigned pick_len(input int unsigned dim);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(257, 511);
            2, 3:    return $urandom_range(1, 256);
            default: return $urandom_range(1, (dim == 0) ? 1 : dim);
        endcase
    endfunction

    function automatic draw_item_t random_item();
        draw_item_t  it;
        int unsigned sel;
        int unsigned hi;
        int unsigned area;
        area = eff_w * eff_h;
        sel = $urandom_range(0, 99);
        it = make_item(REQ_SET_PIXEL, pick_pos(eff_w), pick_pos(eff_h),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
        if (sel < 18)
        begin
            it.kind = REQ_SET_PIXEL;
        end
        else if (sel < 32)
        begin
            it.kind = REQ_HSPAN;
            hi = (eff_w > 32'(it.col)) ? eff_w - 1 : 32'(it.col);
            if ($urandom_range(0, 3) == 0)
                hi = 255;
            if ($urandom_range(0, 6) == 0)
                it.col_end = COORD_W'(pick_pos(eff_w));
            else
                it.col_end = COORD_W'($urandom_range(32'(it.col), hi));
        end
        else if (sel < 46)
        begin
            it.kind = REQ_VSPAN;
            hi = (eff_h > 32'(it.row)) ? eff_h - 1 : 32'(it.row);
            if ($urandom_range(0, 3) == 0)
                hi = 255;
            if ($urandom_range(0, 6) == 0)
                it.row_end = COORD_W'(pick_pos(eff_h));
            else
                it.row_end = COORD_W'($urandom_range(32'(it.row), hi));
        end
        else if (sel < 64)
        begin
            it.kind = REQ_RECT_FILL;
            if (area > FAST_AREA)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    it.rect_width  = DIM_W'(pick_len(eff_w));
                    it.rect_height = DIM_W'($urandom_range(1, 4));
                end
                else
                begin
                    it.rect_width  = DIM_W'($urandom_range(1, 4));
                    it.rect_height = DIM_W'(pick_len(eff_h));
                end
            end
            else
            begin
                it.rect_width  = DIM_W'(pick_len(eff_w));
                it.rect_height = DIM_W'(pick_len(eff_h));
            end
        end
        else if (sel < 88 || (sel < 95 && area > FAST_AREA))
        begin
            it.kind = REQ_READ_PIXEL;
        end
        else if (sel < 95)
        begin
            it.kind = REQ_FILL_FRAME;
        end
        else
        begin
            it.kind = ($urandom_range(0, 1) == 0) ? REQ_RESERVED_A : REQ_RESERVED_B;
        end
        return it;
    endfunction

    // Leaves valid high after the transfer so that a request with no gap
    // follows without a low cycle.
    task automatic send_request(input draw_item_t it);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.kind;
        req_ch.col         <= it.col;
        req_ch.row         <= it.row;
        req_ch.col_end     <= it.col_end;
        req_ch.row_end     <= it.row_end;
        req_ch.rect_width  <= it.rect_width;
        req_ch.rect_height <= it.rect_height;
        req_ch.color       <= it.color;
        do @(posedge clk); while (!req_ch.ready);
        case (it.kind)
            REQ_READ_PIXEL:             read_count++;
            REQ_HSPAN, REQ_VSPAN:       span_count++;
            REQ_RECT_FILL, REQ_FILL_FRAME: fill_count++;
            default: ;
        endcase
        if (it.kind <= REQ_FILL_FRAME)
            useful_count++;
    endtask

    task automatic wait_results_done();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_register(input reg_index_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eff_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        eff_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        frame_count++;
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int unsigned gap;
            gap = rsp_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= '0;
        req_ch.col         <= '0;
        req_ch.row         <= '0;
        req_ch.col_end     <= '0;
        req_ch.row_end     <= '0;
        req_ch.rect_width  <= '0;
        req_ch.rect_height <= '0;
        req_ch.color       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The whole store is written first so that every later read is defined.
        set_frame(256, 256);
        send_request(make_item(REQ_FILL_FRAME, 0, 0, 0, 0, 0, 0, $urandom));
        send_request(make_item(REQ_SET_PIXEL, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_item(REQ_SET_PIXEL, 255, 255, 0, 0, 0, 0, 32'h0000_0000));
        send_request(make_item(REQ_READ_PIXEL, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_READ_PIXEL, 255, 255, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_HSPAN, 0, 0, 255, 0, 0, 0, 32'hA5A5_5A5A));
        send_request(make_item(REQ_HSPAN, 10, 3, 9, 0, 0, 0, $urandom));
        send_request(make_item(REQ_VSPAN, 255, 0, 0, 255, 0, 0, 32'h5A5A_A5A5));
        send_request(make_item(REQ_VSPAN, 7, 200, 0, 100, 0, 0, $urandom));
        send_request(make_item(REQ_RECT_FILL, 0, 0, 0, 0, 256, 256, $urandom));
        send_request(make_item(REQ_RECT_FILL, 5, 5, 0, 0, 0, 20, $urandom));
        send_request(make_item(REQ_RECT_FILL, 5, 5, 0, 0, 20, 0, $urandom));
        send_request(make_item(REQ_RECT_FILL, 200, 200, 0, 0, 511, 511, $urandom));
        send_request(make_item(REQ_READ_PIXEL, 255, 255, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_RESERVED_A, 1, 1, 2, 2, 3, 3, $urandom));
        send_request(make_item(REQ_RESERVED_B, 1, 1, 2, 2, 3, 3, $urandom));

        wait_results_done();
        set_frame(0, 0);
        send_request(make_item(REQ_SET_PIXEL, 0, 0, 0, 0, 0, 0, $urandom));
        send_request(make_item(REQ_READ_PIXEL, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_FILL_FRAME, 0, 0, 0, 0, 0, 0, $urandom));
        send_request(make_item(REQ_RECT_FILL, 0, 0, 0, 0, 3, 3, $urandom));
        send_request(make_item(REQ_HSPAN, 0, 0, 5, 0, 0, 0, $urandom));

        wait_results_done();
        set_frame(511, 511);
        send_request(make_item(REQ_READ_PIXEL, 255, 255, 0, 0, 0, 0, 0));
        send_request(make_item(REQ_SET_PIXEL, 255, 0, 0, 0, 0, 0, $urandom));
        send_request(make_item(REQ_READ_PIXEL, 255, 0, 0, 0, 0, 0, 0));

        while (useful_count < ITEM_TARGET)
        begin
            wait_results_done();
            case ($urandom_range(0, 9))
                0:
                begin
                    w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 24);
                    h = (w == 0) ? $urandom_range(0, 24) : 0;
                end
                1, 2:
                begin
                    w = $urandom_range(1, 511);
                    h = $urandom_range(1, 511);
                end
                3:
                begin
                    case ($urandom_range(0, 2))
                        0:       w = 1;
                        1:       w = 256;
                        default: w = 511;
                    endcase
                    case ($urandom_range(0, 2))
                        0:       h = 1;
                        1:       h = 256;
                        default: h = 511;
                    endcase
                end
                default:
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 24);
                end
            endcase
            set_frame(w, h);
            send_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet  = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            repeat (n)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_results_done();
                send_request(random_item());
            end
        end

        wait_results_done();
        repeat (16) @(posedge clk);
        $display("Run covered %0d requests: %0d reads, %0d spans, %0d rect or frame fills,",
                 useful_count, read_count, span_count, fill_count);
        $display("over %0d frame sizes including empty and oversized frames.", frame_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
